// ===== hdl/bee_pkg.sv =====
// Shared constants, types and helpers for the binary edge extractor.
`default_nettype none

package bee_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PEND_W     = $clog2(MAX_WIDTH + 2);

    localparam int DIM_W      = 13;
    localparam int THR_W      = 9;
    localparam int GRAY_W     = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int LINE_W     = 2;
    localparam int WIN_W      = 9;
    localparam int WIN_CENTER = 4;
    localparam logic [WIN_W-1:0] WIN_FULL = '1;

    localparam int OUT_DEPTH  = 3;
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

    localparam logic [DIM_W-1:0] WIDTH_RST     = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST    = 13'd480;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 9'h080;
    localparam logic             BYPASS_RST    = 1'b0;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_INK_THRESHOLD,
        REG_BYPASS_EDGES
    } cfg_reg_t;

    // request handed from the scan control to the window stage
    typedef struct packed {
        logic             is_drain;
        logic             emit;
        logic             ink;
        logic [COL_W-1:0] col;
        logic             interior;
        logic             frame_end;
        logic             sel_b;
    } issue_t;

    typedef struct packed {
        logic edge_ink;
        logic frame_end;
    } result_t;

    function automatic logic [COL_W-1:0] width_last(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (32'(v) > MAX_WIDTH) begin
            return COL_W'(MAX_WIDTH - 1);
        end else begin
            return COL_W'(v - 1'b1);
        end
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (32'(v) > MAX_HEIGHT) begin
            return ROW_W'(MAX_HEIGHT - 1);
        end else begin
            return ROW_W'(v - 1'b1);
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bee_line_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bee_line_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/bee_scan_ctrl.sv =====
// Configuration registers, scan position counters and request issue.
`default_nettype none

module bee_scan_ctrl (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bee_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bee_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                accept,
    input  wire logic                                s_operation,
    input  wire logic [bee_pkg::GRAY_W-1:0]          s_gray_level,
    output bee_pkg::issue_t                          issue,
    output logic                                     bypass,
    output logic                                     clear
);

    logic [bee_pkg::COL_W-1:0]  w_last_reg;
    logic [bee_pkg::ROW_W-1:0]  h_last_reg;
    logic [bee_pkg::THR_W-1:0]  thr_reg;
    logic                       bypass_reg;

    logic [bee_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [bee_pkg::ROW_W-1:0]  in_row_reg, in_row_next;
    logic [bee_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [bee_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [bee_pkg::PEND_W-1:0] pend_reg, pend_next;

    logic [bee_pkg::PEND_W-1:0] w_full;
    logic                       over_row;
    logic                       is_drain;
    logic                       emit;

    assign clear = cfg_wr_en
        && (bee_pkg::cfg_reg_t'(cfg_index) == bee_pkg::REG_IMAGE_WIDTH
            || bee_pkg::cfg_reg_t'(cfg_index) == bee_pkg::REG_IMAGE_HEIGHT);

    assign bypass   = bypass_reg;
    assign w_full   = bee_pkg::PEND_W'(w_last_reg) + 1'b1;
    assign over_row = pend_reg > w_full;
    assign is_drain = s_operation == bee_pkg::OP_DRAIN;
    assign emit     = is_drain ? (pend_reg != '0) : over_row;

    always_comb begin
        issue.is_drain  = is_drain;
        issue.emit      = emit;
        issue.ink       = {1'b0, s_gray_level} < thr_reg;
        issue.col       = is_drain ? out_col_reg : in_col_reg;
        issue.interior  = out_row_reg != '0 && out_row_reg != h_last_reg
                       && out_col_reg != '0 && out_col_reg != w_last_reg;
        issue.frame_end = out_row_reg == h_last_reg && out_col_reg == w_last_reg;
        issue.sel_b     = over_row;
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (accept && !is_drain) begin
            if (in_col_reg == w_last_reg) begin
                in_col_next = '0;
                in_row_next = (in_row_reg == h_last_reg) ? '0 : in_row_reg + 1'b1;
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (!over_row) begin
                pend_next = pend_reg + 1'b1;
            end
        end
        if (accept && emit) begin
            if (out_col_reg == w_last_reg) begin
                out_col_next = '0;
                out_row_next = (out_row_reg == h_last_reg) ? '0 : out_row_reg + 1'b1;
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
            if (is_drain) begin
                pend_next = pend_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= bee_pkg::width_last(bee_pkg::WIDTH_RST);
            h_last_reg <= bee_pkg::height_last(bee_pkg::HEIGHT_RST);
            thr_reg    <= bee_pkg::THRESHOLD_RST;
            bypass_reg <= bee_pkg::BYPASS_RST;
        end else if (cfg_wr_en) begin
            unique case (bee_pkg::cfg_reg_t'(cfg_index))
                bee_pkg::REG_IMAGE_WIDTH: begin
                    w_last_reg <= bee_pkg::width_last(cfg_data);
                end
                bee_pkg::REG_IMAGE_HEIGHT: begin
                    h_last_reg <= bee_pkg::height_last(cfg_data);
                end
                bee_pkg::REG_INK_THRESHOLD: begin
                    thr_reg <= cfg_data[bee_pkg::THR_W-1:0];
                end
                bee_pkg::REG_BYPASS_EDGES: begin
                    bypass_reg <= cfg_data[0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bee_window.sv =====
// Line store read-modify-write, 3x3 window and boundary decision.
`default_nettype none

module bee_window (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          clear,
    input  wire logic                          issue_valid,
    input  wire bee_pkg::issue_t               issue,
    input  wire logic                          bypass,
    input  wire logic [bee_pkg::LINE_W-1:0]    rd_data,
    output logic                               wr_en,
    output logic      [bee_pkg::COL_W-1:0]     wr_addr,
    output logic      [bee_pkg::LINE_W-1:0]    wr_data,
    output logic                               res_valid,
    output bee_pkg::result_t                   res,
    output logic                               busy
);

    logic                          s1_valid_reg;
    bee_pkg::issue_t               s1_reg;
    logic                          fwd_reg;
    logic [bee_pkg::LINE_W-1:0]    fwd_data_reg;
    logic [bee_pkg::WIN_W-1:0]     win_reg;

    logic [bee_pkg::LINE_W-1:0]    line;
    logic                          up1, up2;
    logic [bee_pkg::WIN_W-1:0]     win_shift;
    logic                          keep;
    logic                          ink;

    // line entry: bit 1 = two rows back, bit 0 = one row back
    assign line      = fwd_reg ? fwd_data_reg : rd_data;
    assign up1       = line[0];
    assign up2       = line[1];
    assign wr_en     = s1_valid_reg && !s1_reg.is_drain;
    assign wr_addr   = s1_reg.col;
    assign wr_data   = {up1, s1_reg.ink};
    assign win_shift = {win_reg[bee_pkg::WIN_W-4:0], up2, up1, s1_reg.ink};
    assign keep      = !s1_reg.is_drain && s1_reg.interior
                    && win_shift == bee_pkg::WIN_FULL;
    assign ink       = s1_reg.is_drain ? (s1_reg.sel_b ? up2 : up1)
                                       : win_shift[bee_pkg::WIN_CENTER];

    assign res_valid     = s1_valid_reg && s1_reg.emit;
    assign res.edge_ink  = bypass ? ink : (ink && !keep);
    assign res.frame_end = s1_reg.frame_end;
    assign busy          = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_valid) begin
            s1_reg       <= issue;
            fwd_reg      <= wr_en && wr_addr == issue.col;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            win_reg <= '0;
        end else if (wr_en) begin
            win_reg <= win_shift;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bee_out_fifo.sv =====
// Three-entry result buffer between the window stage and the output port.
`default_nettype none

module bee_out_fifo (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           push,
    input  wire bee_pkg::result_t               push_data,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output bee_pkg::result_t                    out_data,
    output logic      [bee_pkg::OUT_CNT_W-1:0]  count
);

    bee_pkg::result_t                 entry [bee_pkg::OUT_DEPTH];
    logic [bee_pkg::OUT_PTR_W-1:0]    head_reg, tail_reg;
    logic [bee_pkg::OUT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                             pop;

    function automatic logic [bee_pkg::OUT_PTR_W-1:0] ptr_inc(
        input logic [bee_pkg::OUT_PTR_W-1:0] p);
        return (p == bee_pkg::OUT_PTR_W'(bee_pkg::OUT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_valid = cnt_reg != '0;
    assign out_data  = entry[head_reg];
    assign pop       = out_valid && out_ready;
    assign count     = cnt_reg;

    always_comb begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                tail_reg <= ptr_inc(tail_reg);
            end
            if (pop) begin
                head_reg <= ptr_inc(head_reg);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/binary_edge_extract_3x3.sv =====
// Top level of the 3x3 inner-boundary extractor for thresholded pixels.
//
//  port group   | direction | handshake          | payload
//  -------------+-----------+--------------------+-------------------------------
//  cfg_*        | in        | cfg_wr_en          | cfg_index, cfg_data
//  s_*          | in        | s_valid / s_ready  | s_operation, s_gray_level
//  m_*          | out       | m_valid / m_ready  | m_edge_ink, m_frame_end
//
// One request per cycle while s_ready is high; a result passes through the window
// stage register (line store read) and then the result buffer before it leaves.
// The line store is one 2-bit wide RAM with a single read and a single write
// port; back-to-back hits on one column go through a forwarding register.
// The line store is not cleared by reset.
// s_ready drops when the three-entry result buffer plus the request in the
// window stage would fill it.
`default_nettype none

module binary_edge_extract_3x3 (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bee_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bee_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic [bee_pkg::GRAY_W-1:0]        s_gray_level,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_edge_ink,
    output logic                                   m_frame_end
);

    logic                              accept;
    bee_pkg::issue_t                   issue;
    logic                              bypass;
    logic                              clear;
    logic [bee_pkg::LINE_W-1:0]        rd_data;
    logic                              wr_en;
    logic [bee_pkg::COL_W-1:0]         wr_addr;
    logic [bee_pkg::LINE_W-1:0]        wr_data;
    logic                              res_valid;
    bee_pkg::result_t                  res;
    logic                              s1_busy;
    bee_pkg::result_t                  out_data;
    logic [bee_pkg::OUT_CNT_W-1:0]     fifo_cnt;
    logic [bee_pkg::OUT_CNT_W:0]       occupancy;

    assign occupancy = {1'b0, fifo_cnt} + {{bee_pkg::OUT_CNT_W{1'b0}}, s1_busy};
    assign s_ready   = occupancy < (bee_pkg::OUT_CNT_W + 1)'(bee_pkg::OUT_DEPTH);
    assign accept    = s_valid && s_ready;

    assign m_edge_ink  = out_data.edge_ink;
    assign m_frame_end = out_data.frame_end;

    bee_scan_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .s_operation  (s_operation),
        .s_gray_level (s_gray_level),
        .issue        (issue),
        .bypass       (bypass),
        .clear        (clear)
    );

    bee_line_ram #(
        .WIDTH (bee_pkg::LINE_W),
        .DEPTH (bee_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (issue.col),
        .rd_data (rd_data)
    );

    bee_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (clear),
        .issue_valid (accept),
        .issue       (issue),
        .bypass      (bypass),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .res_valid   (res_valid),
        .res         (res),
        .busy        (s1_busy)
    );

    bee_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .count     (fifo_cnt)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (fifo_cnt != bee_pkg::OUT_CNT_W'(bee_pkg::OUT_DEPTH)) || m_ready)
        else $error("result buffer overflow");

    a_issue_reaches_window: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_busy)
        else $error("accepted request missing from window stage");

    a_write_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> s1_busy && !clear)
        else $error("line store write outside an active request");

endmodule

`default_nettype wire

// ===== tb/sv/binary_edge_extract_3x3_tb.sv =====
// Self-checking testbench for the 3x3 inner-boundary extractor: directed table, random frames.
`timescale 1ns / 100ps

module binary_edge_extract_3x3_tb;

    localparam int ITEM_GOAL   = 1450;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RES
    } chk_t;

    typedef struct packed {
        logic                           is_cfg;
        bee_pkg::cfg_reg_t              idx;
        logic [bee_pkg::CFG_DATA_W-1:0] data;
        logic                           op;
        logic [bee_pkg::GRAY_W-1:0]     gray;
        chk_t                           chk;
        bee_pkg::result_t               typed;
    } plan_row_t;

    logic                           aclk;
    logic                           aresetn      = 1'b0;
    logic                           cfg_wr_en    = 1'b0;
    bee_pkg::cfg_reg_t              cfg_index    = bee_pkg::REG_IMAGE_WIDTH;
    logic [bee_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic                           s_operation  = bee_pkg::OP_PIXEL;
    logic [bee_pkg::GRAY_W-1:0]     s_gray_level = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic                           m_edge_ink;
    logic                           m_frame_end;

    // predictor copy of the block state and registers
    bit                        line_a [bee_pkg::MAX_WIDTH];
    bit                        line_b [bee_pkg::MAX_WIDTH];
    logic [bee_pkg::WIN_W-1:0] win = '0;
    int unsigned               in_col, in_row, out_col, out_row, pend;
    logic [bee_pkg::DIM_W-1:0] geo_width  = bee_pkg::WIDTH_RST;
    logic [bee_pkg::DIM_W-1:0] geo_height = bee_pkg::HEIGHT_RST;
    logic [bee_pkg::THR_W-1:0] ink_thr    = bee_pkg::THRESHOLD_RST;
    logic                      pass_thru  = bee_pkg::BYPASS_RST;

    bee_pkg::result_t boundary_q [$];
    int unsigned      n_fail, n_items, quiet;
    int unsigned      send_idle_pct, recv_stall_pct;

    binary_edge_extract_3x3 uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_gray_level (s_gray_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_ink   (m_edge_ink),
        .m_frame_end  (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned eff_dim(logic [bee_pkg::DIM_W-1:0] v, int unsigned lim);
        if (v == '0) begin
            return 1;
        end
        return (v > lim) ? lim : int'(v);
    endfunction

    function automatic plan_row_t cfg_row(bee_pkg::cfg_reg_t idx,
                                          logic [bee_pkg::CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic plan_row_t req_row(logic op, logic [bee_pkg::GRAY_W-1:0] gray,
                                          chk_t chk, logic ink_e, logic fe);
        plan_row_t r;
        r = '0;
        r.op = op;
        r.gray = gray;
        r.chk = chk;
        r.typed.edge_ink = ink_e;
        r.typed.frame_end = fe;
        return r;
    endfunction

    task automatic clear_pipe();
        win = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        pend = 0;
    endtask

    task automatic step_pos(inout int unsigned col, inout int unsigned row,
                            input int unsigned w, input int unsigned h);
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) begin
                row = 0;
            end
        end
    endtask

    // boundary bit for one request, or none
    task automatic boundary_step(input logic op, input logic [bee_pkg::GRAY_W-1:0] gray,
                                 output bit has, output bee_pkg::result_t res);
        int unsigned w, h;
        bit ink, keep, now, up1, up2;
        w = eff_dim(geo_width, bee_pkg::MAX_WIDTH);
        h = eff_dim(geo_height, bee_pkg::MAX_HEIGHT);
        has = 1'b0;
        res = '0;
        keep = 1'b0;
        if (in_col >= w || in_row >= h || out_col >= w || out_row >= h) begin
            clear_pipe();
        end
        if (op == bee_pkg::OP_PIXEL) begin
            now = ({1'b0, gray} < ink_thr);
            up1 = line_a[in_col];
            up2 = line_b[in_col];
            line_b[in_col] = up1;
            line_a[in_col] = now;
            win = {win[5:0], up2, up1, now};
            step_pos(in_col, in_row, w, h);
            pend++;
            if (pend <= w + 1) begin
                return;
            end
            ink = win[bee_pkg::WIN_CENTER];
            if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
                keep = (win == bee_pkg::WIN_FULL);
            end
        end else begin
            if (pend == 0) begin
                return;
            end
            // neighbours not seen yet: never survives erosion
            ink = (pend > w) ? line_b[out_col] : line_a[out_col];
        end
        res.edge_ink = pass_thru ? ink : (ink && !keep);
        res.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
        step_pos(out_col, out_row, w, h);
        pend--;
        has = 1'b1;
    endtask

    task automatic flag_mismatch(input string msg);
        n_fail++;
        $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    task automatic cfg_write(input bee_pkg::cfg_reg_t idx,
                             input logic [bee_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bee_pkg::REG_IMAGE_WIDTH: begin
                geo_width = data;
                clear_pipe();
            end
            bee_pkg::REG_IMAGE_HEIGHT: begin
                geo_height = data;
                clear_pipe();
            end
            bee_pkg::REG_INK_THRESHOLD: ink_thr = data[bee_pkg::THR_W-1:0];
            default: pass_thru = data[0];
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_results(input int unsigned cycles);
        s_valid <= 1'b0;
        while (boundary_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic send_req(input logic op, input logic [bee_pkg::GRAY_W-1:0] gray,
                            input chk_t chk, input bee_pkg::result_t typed);
        bit has;
        bee_pkg::result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_gray_level <= gray;
        @(posedge aclk);
        while (s_ready !== 1'b1) begin
            @(posedge aclk);
        end
        if (op == bee_pkg::OP_PIXEL || pend != 0) begin
            n_items++;
        end
        boundary_step(op, gray, has, res);
        if (chk == CHK_RES) begin
            boundary_q.push_back(typed);
        end else if (chk == CHK_MODEL && has) begin
            boundary_q.push_back(res);
        end
    endtask

    always @(posedge aclk) begin : result_check
        bee_pkg::result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (boundary_q.size() == 0) begin
                flag_mismatch("result with nothing expected");
            end else begin
                want = boundary_q.pop_front();
                if (m_edge_ink !== want.edge_ink) begin
                    flag_mismatch($sformatf("edge_ink %b, want %b", m_edge_ink, want.edge_ink));
                end
                if (m_frame_end !== want.frame_end) begin
                    flag_mismatch($sformatf("frame_end %b, want %b",
                                            m_frame_end, want.frame_end));
                end
            end
        end
        m_ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : driver
        plan_row_t                  plan [$];
        int unsigned                phase, w, h, n_pix, k, pause_at, n_drain;
        int unsigned                r0, r1, c0, c1;
        bit                         big, big_prev, noisy, want, in_box;
        logic [bee_pkg::GRAY_W-1:0] g;

        r0 = 0;
        r1 = 0;
        c0 = 0;
        c1 = 0;
        noisy = 1'b0;
        big_prev = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset geometry, 1x1 frames, extremes of threshold, tiny 3x3 frame
        plan.push_back(req_row(bee_pkg::OP_DRAIN, 8'hA5, CHK_NONE, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'h00, CHK_NONE, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_DRAIN, 8'h00, CHK_RES, 1'b1, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'hFF, CHK_NONE, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_DRAIN, 8'h00, CHK_RES, 1'b0, 1'b0));
        plan.push_back(cfg_row(bee_pkg::REG_IMAGE_WIDTH, 13'd1));
        plan.push_back(cfg_row(bee_pkg::REG_IMAGE_HEIGHT, 13'd1));
        plan.push_back(cfg_row(bee_pkg::REG_INK_THRESHOLD, 13'd256));
        plan.push_back(cfg_row(bee_pkg::REG_BYPASS_EDGES, 13'd0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'hFF, CHK_NONE, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'hFF, CHK_NONE, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'h00, CHK_RES, 1'b1, 1'b1));
        plan.push_back(req_row(bee_pkg::OP_DRAIN, 8'h00, CHK_RES, 1'b1, 1'b1));
        plan.push_back(req_row(bee_pkg::OP_DRAIN, 8'h00, CHK_RES, 1'b1, 1'b1));
        plan.push_back(req_row(bee_pkg::OP_DRAIN, 8'h00, CHK_NONE, 1'b0, 1'b0));
        plan.push_back(cfg_row(bee_pkg::REG_INK_THRESHOLD, 13'd0));
        plan.push_back(cfg_row(bee_pkg::REG_BYPASS_EDGES, 13'd1));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'h00, CHK_NONE, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'h80, CHK_NONE, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'hFF, CHK_RES, 1'b0, 1'b1));
        plan.push_back(cfg_row(bee_pkg::REG_IMAGE_WIDTH, 13'd0));
        plan.push_back(cfg_row(bee_pkg::REG_IMAGE_HEIGHT, 13'd0));
        plan.push_back(cfg_row(bee_pkg::REG_INK_THRESHOLD, 13'd255));
        plan.push_back(cfg_row(bee_pkg::REG_BYPASS_EDGES, 13'd0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'hFE, CHK_MODEL, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_PIXEL, 8'hFF, CHK_MODEL, 1'b0, 1'b0));
        plan.push_back(req_row(bee_pkg::OP_DRAIN, 8'h00, CHK_MODEL, 1'b0, 1'b0));
        plan.push_back(cfg_row(bee_pkg::REG_IMAGE_WIDTH, 13'd3));
        plan.push_back(cfg_row(bee_pkg::REG_IMAGE_HEIGHT, 13'd3));
        plan.push_back(cfg_row(bee_pkg::REG_INK_THRESHOLD, 13'd128));
        for (k = 0; k < 9; k++) begin
            g = (k == 8) ? 8'd127 : ((k == 0) ? 8'd0 : bee_pkg::GRAY_W'(1 << (k - 1)));
            plan.push_back(req_row(bee_pkg::OP_PIXEL, g, CHK_MODEL, 1'b0, 1'b0));
        end
        plan.push_back(req_row(bee_pkg::OP_DRAIN, 8'h00, CHK_MODEL, 1'b0, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_results(DRAIN_WAIT);
                cfg_write(plan[i].idx, plan[i].data);
            end else begin
                send_req(plan[i].op, plan[i].gray, plan[i].chk, plan[i].typed);
            end
        end

        phase = 0;
        while (n_items < ITEM_GOAL) begin
            wait_results(DRAIN_WAIT);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 49;
                end
                default: begin
                    send_idle_pct = 33;
                    recv_stall_pct = 33;
                end
            endcase

            big = (phase == 1 || phase == 3 || phase == 5 || phase == 7);
            if (big) begin
                case (phase)
                    1: begin
                        cfg_write(bee_pkg::REG_IMAGE_WIDTH, 13'd4096);
                        cfg_write(bee_pkg::REG_IMAGE_HEIGHT, 13'd2);
                    end
                    3: begin
                        cfg_write(bee_pkg::REG_IMAGE_WIDTH, 13'd8191);
                        cfg_write(bee_pkg::REG_IMAGE_HEIGHT, 13'd8191);
                    end
                    5: begin
                        cfg_write(bee_pkg::REG_IMAGE_WIDTH, 13'd1);
                        cfg_write(bee_pkg::REG_IMAGE_HEIGHT, 13'd4096);
                    end
                    default: begin
                        cfg_write(bee_pkg::REG_IMAGE_WIDTH, 13'd0);
                        cfg_write(bee_pkg::REG_IMAGE_HEIGHT, 13'd0);
                    end
                endcase
            end else if (phase == 0 || big_prev || $urandom_range(0, 4) != 0) begin
                cfg_write(bee_pkg::REG_IMAGE_WIDTH, bee_pkg::CFG_DATA_W'($urandom_range(1, 12)));
                cfg_write(bee_pkg::REG_IMAGE_HEIGHT, bee_pkg::CFG_DATA_W'($urandom_range(1, 8)));
            end
            big_prev = big;
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 5))
                    0: cfg_write(bee_pkg::REG_INK_THRESHOLD, 13'd0);
                    1: cfg_write(bee_pkg::REG_INK_THRESHOLD, 13'd256);
                    2: cfg_write(bee_pkg::REG_INK_THRESHOLD, 13'd128);
                    default: cfg_write(bee_pkg::REG_INK_THRESHOLD,
                                       bee_pkg::CFG_DATA_W'($urandom_range(1, 255)));
                endcase
            end
            if ($urandom_range(0, 1) == 1) begin
                cfg_write(bee_pkg::REG_BYPASS_EDGES,
                          ($urandom_range(0, 3) == 0) ? 13'd1 : 13'd0);
            end

            w = eff_dim(geo_width, bee_pkg::MAX_WIDTH);
            h = eff_dim(geo_height, bee_pkg::MAX_HEIGHT);
            if (big) begin
                n_pix = $urandom_range(40, 80);
            end else begin
                n_pix = w * h * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) begin
                    n_pix += $urandom_range(1, w * h);
                end
            end
            pause_at = (phase == 0 || $urandom_range(0, 4) == 0) ? n_pix / 2 : n_pix;

            for (k = 0; k < n_pix; k++) begin
                if (k == pause_at) begin
                    wait_results(1);
                end
                if ($urandom_range(99) < 3) begin
                    send_req(bee_pkg::OP_DRAIN, bee_pkg::GRAY_W'($urandom_range(0, 255)),
                             CHK_MODEL, '0);
                end
                if (in_col == 0 && in_row == 0) begin
                    noisy = ($urandom_range(0, 4) == 0);
                    r0 = $urandom_range(0, h - 1);
                    r1 = $urandom_range(r0, h - 1);
                    c0 = $urandom_range(0, w - 1);
                    c1 = $urandom_range(c0, w - 1);
                end
                in_box = (in_row >= r0 && in_row <= r1 && in_col >= c0 && in_col <= c1);
                if (noisy) begin
                    want = $urandom_range(0, 1);
                end else begin
                    want = in_box ? ($urandom_range(99) < 95) : ($urandom_range(99) < 8);
                end
                if (want && ink_thr != 0) begin
                    g = bee_pkg::GRAY_W'($urandom_range(0, ink_thr - 1));
                end else if (!want && ink_thr <= 255) begin
                    g = bee_pkg::GRAY_W'($urandom_range(ink_thr, 255));
                end else begin
                    g = bee_pkg::GRAY_W'($urandom_range(0, 255));
                end
                send_req(bee_pkg::OP_PIXEL, g, CHK_MODEL, '0);
            end

            // some phases leave results pending; the next geometry write drops them
            if (big || $urandom_range(0, 3) != 0) begin
                n_drain = pend + $urandom_range(0, 2);
                repeat (n_drain) begin
                    send_req(bee_pkg::OP_DRAIN, bee_pkg::GRAY_W'($urandom_range(0, 255)),
                             CHK_MODEL, '0);
                end
            end
            phase++;
        end

        wait_results(16);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bee_pkg.sv
hdl/bee_line_ram.sv
hdl/bee_scan_ctrl.sv
hdl/bee_window.sv
hdl/bee_out_fifo.sv
hdl/binary_edge_extract_3x3.sv
tb/sv/binary_edge_extract_3x3_tb.sv
